>>> rtl/nms_pkg.sv
// Shared types and constants of the four-neighbour mean smoothing block.
// No dependencies; used by nms_mean and neighbour_mean_smoothing.
package nms_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 18;   // sum of up to four samples
    localparam int MAG_W        = 18;
    localparam int MEAN_W       = 24;   // Q16.8 result
    localparam int ROWS_W       = 13;
    localparam int COLS_W       = 11;
    localparam int ROW_W        = 12;
    localparam int MAX_ROWS     = 4096;
    localparam int MAX_COLS_DEF = 1024;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = ROWS_W;

    // Division by three as multiply by reciprocal: exact for numerators below 2**27
    localparam int RECIP_SHIFT  = 27;
    localparam int RECIP_W      = 26;
    localparam int NUM_W        = MAG_W + 8;
    localparam int PROD_W       = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((2**RECIP_SHIFT + 1) / 3);

    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(8);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        DIV_2,
        DIV_3,
        DIV_4
    } div_kind_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        div_kind_t               kind;
        logic                    last;
    } mean_req_t;

endpackage

>>> rtl/neighbour_mean_smoothing.sv
// Four-neighbour mean smoothing of a raster-order frame, two line buffers in RAM.
// Depends on nms_pkg, nms_ram and nms_mean.
//
// Input channel (in_valid / in_stall): one beat per command. cmd = push carries a
// sample of the frame; cmd = drain asks for one result of the last row once the
// whole frame is in. Pushes during the drain phase and drains before it are
// dropped without a result. Output channel (out_valid / out_stall): one beat per
// result, smoothed in Q16.8 and frame_last on the final result of the frame.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets rows,
// index 1 sets cols; either write restarts the frame, line buffers are kept.
// Write it only while no result is outstanding.
// Throughput: one beat per cycle unless in_stall is high. Each beat does one read
// and at most one write on each line buffer RAM, with reads issued ahead for the
// next column; a same-address read/write is forwarded around the RAM.
// A result passes the sum stage, multiply stage and output register after the
// beat that causes it. The result of row r lags its input by one row; the first
// row gives none.
// When the receiver stalls, up to three results are held and then in_stall rises.
// Reset clears all position counters and sets rows and cols to 8; buffers are not
// cleared and no clearing pass is needed.
module neighbour_mean_smoothing #(
    parameter int MAX_COLS = nms_pkg::MAX_COLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [nms_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [nms_pkg::MEAN_W-1:0]    smoothed,
    output logic                                 frame_last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int LW = (CW + 1 > nms_pkg::COLS_W) ? CW + 1 : nms_pkg::COLS_W;
    localparam logic [LW-1:0] MAXC_L = LW'(MAX_COLS);

    // configuration
    logic [nms_pkg::ROWS_W-1:0] rows_reg;
    logic [nms_pkg::COLS_W-1:0] cols_reg;
    logic [LW-1:0]              cols_ext;
    logic [CW-1:0]              last_col;
    logic [nms_pkg::ROW_W-1:0]  last_row;
    logic                       cfg_we;
    logic                       cfg_hit;

    // positions
    logic [CW-1:0]              col_reg;
    logic [CW-1:0]              col_next;
    logic [nms_pkg::ROW_W-1:0]  in_row_reg;
    logic [nms_pkg::ROW_W-1:0]  in_row_next;
    logic                       draining_reg;
    logic                       draining_next;

    // neighbour window
    logic signed [nms_pkg::SAMPLE_W-1:0] col0_reg;
    logic signed [nms_pkg::SAMPLE_W-1:0] hold_reg;
    logic signed [nms_pkg::SAMPLE_W-1:0] left_reg;
    logic                                fwd_reg;
    logic signed [nms_pkg::SAMPLE_W-1:0] fwd_data_reg;
    logic signed [nms_pkg::SAMPLE_W-1:0] mid_cur;
    logic signed [nms_pkg::SAMPLE_W-1:0] mid_next;
    logic [nms_pkg::SAMPLE_W-1:0]        above_rd;
    logic [nms_pkg::SAMPLE_W-1:0]        middle_rd;
    logic [CW-1:0]                       middle_raddr;

    // item control
    logic in_acc;
    logic push_act;
    logic drain_act;
    logic emit;
    logic at_last_col;
    logic has_up;
    logic has_left;
    logic has_right;
    logic [2:0] cnt;
    logic signed [nms_pkg::SUM_W-1:0] t_up;
    logic signed [nms_pkg::SUM_W-1:0] t_left;
    logic signed [nms_pkg::SUM_W-1:0] t_right;
    logic signed [nms_pkg::SUM_W-1:0] t_x;

    // sum stage
    logic               s1_valid_reg;
    nms_pkg::mean_req_t s1_req_reg;
    nms_pkg::mean_req_t s1_req_next;
    logic               mean_ready;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_we && (cfg_index == nms_pkg::REG_ROWS ||
                                  cfg_index == nms_pkg::REG_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= nms_pkg::ROWS_RESET;
            cols_reg <= nms_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == nms_pkg::REG_ROWS)
            begin
                rows_reg <= cfg_data;
            end
            else if (cfg_index == nms_pkg::REG_COLS)
            begin
                cols_reg <= cfg_data[nms_pkg::COLS_W-1:0];
            end
        end
    end

    assign cols_ext = LW'(cols_reg);

    always_comb
    begin
        if (cols_ext < LW'(2))
        begin
            last_col = CW'(1);
        end
        else if (cols_ext > MAXC_L)
        begin
            last_col = CW'(MAX_COLS - 1);
        end
        else
        begin
            last_col = CW'(cols_ext - LW'(1));
        end

        if (rows_reg < nms_pkg::ROWS_W'(2))
        begin
            last_row = nms_pkg::ROW_W'(1);
        end
        else if (rows_reg > nms_pkg::ROWS_W'(nms_pkg::MAX_ROWS))
        begin
            last_row = nms_pkg::ROW_W'(nms_pkg::MAX_ROWS - 1);
        end
        else
        begin
            last_row = nms_pkg::ROW_W'(rows_reg - nms_pkg::ROWS_W'(1));
        end
    end

    // ---------------- item decode ----------------
    assign in_acc      = in_valid && !in_stall;
    assign push_act    = in_acc && cmd == nms_pkg::CMD_PUSH && !draining_reg;
    assign drain_act   = in_acc && cmd == nms_pkg::CMD_DRAIN && draining_reg;
    assign emit        = push_act && in_row_reg != '0;
    assign at_last_col = col_reg == last_col;

    // middle[0] is only ever written by a push at column 0, so col0_reg mirrors it
    assign mid_cur  = (col_reg == '0) ? col0_reg : hold_reg;
    assign mid_next = fwd_reg ? fwd_data_reg : $signed(middle_rd);

    assign has_up    = draining_reg || in_row_reg > nms_pkg::ROW_W'(1);
    assign has_left  = col_reg != '0;
    assign has_right = !at_last_col;

    assign t_up    = has_up    ? nms_pkg::SUM_W'($signed(above_rd)) : '0;
    assign t_left  = has_left  ? nms_pkg::SUM_W'(left_reg)          : '0;
    assign t_right = has_right ? nms_pkg::SUM_W'(mid_next)          : '0;
    assign t_x     = draining_reg ? '0 : nms_pkg::SUM_W'(sample);

    assign cnt = 3'(has_up) + 3'(has_left) + 3'(has_right) + 3'(!draining_reg);

    always_comb
    begin
        s1_req_next.sum  = t_up + t_left + t_right + t_x;
        s1_req_next.last = drain_act && at_last_col;
        case (cnt)
            3'd2:    s1_req_next.kind = nms_pkg::DIV_2;
            3'd3:    s1_req_next.kind = nms_pkg::DIV_3;
            3'd4:    s1_req_next.kind = nms_pkg::DIV_4;
            default: s1_req_next.kind = nms_pkg::DIV_4;
        endcase
    end

    // ---------------- position update ----------------
    always_comb
    begin
        col_next      = col_reg;
        in_row_next   = in_row_reg;
        draining_next = draining_reg;
        if (cfg_hit)
        begin
            col_next      = '0;
            in_row_next   = '0;
            draining_next = 1'b0;
        end
        else if (push_act)
        begin
            if (at_last_col)
            begin
                col_next    = '0;
                in_row_next = (in_row_reg == last_row) ? '0 : in_row_reg + 1'b1;
                // last sample of the frame: only drains are taken from here on
                draining_next = in_row_reg == last_row;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else if (drain_act)
        begin
            if (at_last_col)
            begin
                col_next      = '0;
                draining_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            in_row_reg   <= '0;
            draining_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            in_row_reg   <= in_row_next;
            draining_reg <= draining_next;
            fwd_reg      <= push_act && middle_raddr == col_reg;
            if (!in_stall)
            begin
                s1_valid_reg <= emit || drain_act;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= sample;
        if (push_act || drain_act)
        begin
            hold_reg <= mid_next;
            left_reg <= mid_cur;
        end
        if (push_act && col_reg == '0)
        begin
            col0_reg <= sample;
        end
        if (!in_stall && (emit || drain_act))
        begin
            s1_req_reg <= s1_req_next;
        end
    end

    // ---------------- line buffers ----------------
    // read one column ahead so the data is there when the next beat arrives
    assign middle_raddr = (col_next == last_col) ? '0 : col_next + 1'b1;

    nms_ram #(
        .WIDTH (nms_pkg::SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_above (
        .clk   (clk),
        .we    (emit),
        .waddr (col_reg),
        .wdata (mid_cur),
        .raddr (col_next),
        .rdata (above_rd)
    );

    nms_ram #(
        .WIDTH (nms_pkg::SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_middle (
        .clk   (clk),
        .we    (push_act),
        .waddr (col_reg),
        .wdata (sample),
        .raddr (middle_raddr),
        .rdata (middle_rd)
    );

    // ---------------- mean and output ----------------
    assign in_stall = s1_valid_reg && !mean_ready;

    nms_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s1_valid_reg),
        .req        (s1_req_reg),
        .req_ready  (mean_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .smoothed   (smoothed),
        .frame_last (frame_last)
    );

    // ---------------- assertions ----------------
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col)
        else $error("column counter beyond last column");

    a_drain_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> in_row_reg == '0)
        else $error("input row not wrapped during drain");

    a_above_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && col_next == col_reg))
        else $error("above buffer read and write hit the same entry");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_act && at_last_col) |=> !draining_reg && col_reg == '0)
        else $error("frame did not restart after final drain");

endmodule

>>> rtl/nms_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No package dependencies.
module nms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nms_mean.sv
// Rounded Q16.8 mean of a neighbour sum over 2, 3 or 4 terms, two register stages
// with its own output register. Depends on nms_pkg.
module nms_mean (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  nms_pkg::mean_req_t req,
    output logic              req_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [nms_pkg::MEAN_W-1:0] smoothed,
    output logic              frame_last
);

    logic                              s2_valid_reg;
    logic                              s2_neg_reg;
    logic                              s2_last_reg;
    logic [nms_pkg::PROD_W-1:0]        s2_prod_reg;
    logic [nms_pkg::PROD_W-1:0]        prod_next;
    logic [nms_pkg::MAG_W-1:0]         mag;
    logic [nms_pkg::NUM_W-1:0]         num;
    logic [nms_pkg::MEAN_W-1:0]        quot;
    logic                              out_valid_reg;
    logic signed [nms_pkg::MEAN_W-1:0] smoothed_reg;
    logic                              frame_last_reg;
    logic                              out_adv;
    logic                              s2_adv;

    assign out_adv   = !out_valid_reg || !out_stall;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign req_ready = s2_adv;

    assign mag = req.sum[nms_pkg::SUM_W-1] ? nms_pkg::MAG_W'(-req.sum)
                                           : nms_pkg::MAG_W'(req.sum);
    // low bits of mag*256 are zero, so the rounding +1 is an OR
    assign num = {mag, 8'b0} | nms_pkg::NUM_W'(1);

    always_comb
    begin
        case (req.kind)
            nms_pkg::DIV_2: prod_next = nms_pkg::PROD_W'(mag) << (nms_pkg::RECIP_SHIFT + 7);
            nms_pkg::DIV_3: prod_next = nms_pkg::PROD_W'(num) * nms_pkg::PROD_W'(nms_pkg::RECIP_K);
            nms_pkg::DIV_4: prod_next = nms_pkg::PROD_W'(mag) << (nms_pkg::RECIP_SHIFT + 6);
            default:        prod_next = '0;
        endcase
    end

    assign quot = s2_prod_reg[nms_pkg::RECIP_SHIFT +: nms_pkg::MEAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                s2_valid_reg <= req_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && req_valid)
        begin
            s2_prod_reg <= prod_next;
            s2_neg_reg  <= req.sum[nms_pkg::SUM_W-1];
            s2_last_reg <= req.last;
        end
        if (out_adv && s2_valid_reg)
        begin
            smoothed_reg   <= s2_neg_reg ? -$signed(quot) : $signed(quot);
            frame_last_reg <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign smoothed   = smoothed_reg;
    assign frame_last = frame_last_reg;

endmodule
